[hw/rtl/rd64_pkg.sv]
// Shared port types and constants for the restoring divider.
package rd64_pkg;

  // Width of every operand and result port
  localparam int PORT_W = 64;

  typedef logic [PORT_W-1:0] word_t;

  // Result selector codes
  typedef enum logic {
    SEL_QUOTIENT  = 1'b0,
    SEL_REMAINDER = 1'b1
  } sel_t;

endpackage

[hw/rtl/rd64_stage.sv]
// One restoring-division step with its own pipeline register.
module rd64_stage #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_rem,
  input  logic [W-1:0] in_nq,
  input  logic [W-1:0] in_den,
  input  logic         in_sel,
  input  logic         in_dbz,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_rem,
  output logic [W-1:0] out_nq,
  output logic [W-1:0] out_den,
  output logic         out_sel,
  output logic         out_dbz
);

  logic         valid_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] nq_r;
  logic [W-1:0] den_r;
  logic         sel_r;
  logic         dbz_r;

  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         take;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] nq_nxt;

  // Shift the next dividend bit into the partial remainder, then try the subtract.
  // The trial keeps the bit shifted out on top so the compare stays exact.
  assign trial   = {in_rem, in_nq[W-1]};
  assign diff    = {1'b0, trial} - {2'b00, in_den};
  assign take    = ~diff[W+1];
  assign rem_nxt = take ? diff[W-1:0] : trial[W-1:0];
  // Dividend bits leave at the top, quotient bits enter at the bottom
  assign nq_nxt  = {in_nq[W-2:0], take};

  // Stage holds a word until downstream takes it; an empty stage always accepts
  assign in_ready = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= in_den;
      sel_r <= in_sel;
      dbz_r <= in_dbz;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_nq    = nq_r;
  assign out_den   = den_r;
  assign out_sel   = sel_r;
  assign out_dbz   = dbz_r;

endmodule

[hw/rtl/restoring_divider_64.sv]
// Unsigned restoring divider, top level: fully pipelined, one quotient bit per stage.
//
// Divides an unsigned dividend by an unsigned divisor and returns either the
// quotient or the remainder, as in_want_remainder selects. Only the low
// DATA_WIDTH bits of each operand are used, and result bits above DATA_WIDTH
// are zero. A zero divisor returns 0 with out_divide_by_zero set. The
// datapath is a chain of DATA_WIDTH register stages, each doing one restoring
// step (a DATA_WIDTH+1 bit subtract and select); the last stage is the output
// register. The first stage loads at the accepting edge, and out_valid rises
// once the word has passed through every stage; a new word can be accepted
// every cycle unless a stalled output has filled the chain. Each stage stalls
// on its own, so bubbles close up while the output waits.
module restoring_divider_64 #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rd64_pkg::word_t       in_dividend,
  input  rd64_pkg::word_t       in_divisor,
  input  logic                  in_want_remainder,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rd64_pkg::word_t       out_result,
  output logic                  out_divide_by_zero
);
  import rd64_pkg::*;

  localparam int W = DATA_WIDTH;

  logic         vld [0:W];
  logic         rdy [0:W];
  logic [W-1:0] rem [0:W];
  logic [W-1:0] nq  [0:W];
  logic [W-1:0] den [0:W];
  logic         sel [0:W];
  logic         dbz [0:W];
  logic [W-1:0] res_w;

  // Stage 0 inputs come straight from the ports
  assign vld[0]   = in_valid;
  assign rem[0]   = '0;
  assign nq[0]    = in_dividend[W-1:0];
  assign den[0]   = in_divisor[W-1:0];
  assign sel[0]   = in_want_remainder;
  assign dbz[0]   = (in_divisor[W-1:0] == '0);
  assign in_ready = rdy[0];
  assign rdy[W]   = out_ready;

  // Step chain, most significant dividend bit first
  for (genvar i = 0; i < W; i++) begin : g_step
    rd64_stage #(.W(W)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_rem    (rem[i]),
      .in_nq     (nq[i]),
      .in_den    (den[i]),
      .in_sel    (sel[i]),
      .in_dbz    (dbz[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_rem   (rem[i+1]),
      .out_nq    (nq[i+1]),
      .out_den   (den[i+1]),
      .out_sel   (sel[i+1]),
      .out_dbz   (dbz[i+1])
    );
  end

  // Result select; after the last step nq holds the quotient
  always_comb begin
    res_w = '0;
    if (!dbz[W]) begin
      unique case (sel_t'(sel[W]))
        SEL_QUOTIENT:  res_w = nq[W];
        SEL_REMAINDER: res_w = rem[W];
        default:       res_w = '0;
      endcase
    end
  end

  assign out_valid          = vld[W];
  assign out_result         = word_t'(res_w);
  assign out_divide_by_zero = dbz[W];

endmodule

[hw/rtl/rd64_checker.sv]
// Port-level checks for the restoring divider, bound to the top level.
module rd64_checker #(
  parameter int DATA_WIDTH = 64
) (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input rd64_pkg::word_t out_result,
  input logic            out_divide_by_zero
);
  import rd64_pkg::*;

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_divide_by_zero))
    else $error("result payload changed while stalled");

  // Divide by zero always reports a zero result
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result == '0)
    else $error("nonzero result on divide by zero");

  // No result bits above the datapath width
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result >> DATA_WIDTH) == '0)
    else $error("result bits set above data width");

endmodule

bind restoring_divider_64 rd64_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rd64_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result         (out_result),
  .out_divide_by_zero (out_divide_by_zero)
);
